// ===== rtl/core/atam_pkg.sv =====
// Shared types and constants for the averaged temperature alarm monitor.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package atam_pkg;

    // Window geometry (depth must be a power of two: the average is a shift)
    localparam int WINDOW_DEPTH = 32;
    localparam int SAMPLE_BITS  = 10;
    localparam int POS_BITS     = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS     = SAMPLE_BITS + POS_BITS;
    localparam int ALERT_COUNT  = 4;

    // Configuration port geometry
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = 3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [ALERT_COUNT-1:0] alert_t;

    localparam sample_t WINDOW_RESET    = SAMPLE_BITS'(139);
    localparam sample_t THRESHOLD_RESET = SAMPLE_BITS'(213);
    localparam sum_t    SUM_RESET       = SUM_BITS'(139 * WINDOW_DEPTH);

    // Alert bit positions, shared by rearm mask, new and latched alerts
    localparam int ALERT_SUPPLY = 0;
    localparam int ALERT_POWER  = 1;
    localparam int ALERT_ENCL   = 2;
    localparam int ALERT_OPEN   = 3;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_REARM = 1'b1
    } op_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_SUPPLY_THR = 3'd0,
        REG_ENCL_THR   = 3'd1,
        REG_SUPPLY_EN  = 3'd2,
        REG_POWER_EN   = 3'd3,
        REG_ENCL_EN    = 3'd4,
        REG_OPEN_EN    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        op_t     operation;
        sample_t supply_sample;
        sample_t enclosure_sample;
        logic    power_fail_in;
        logic    enclosure_open_in;
        alert_t  rearm_mask;
    } in_item_t;

    typedef struct packed {
        sample_t supply_average;
        sample_t enclosure_average;
        logic    power_fail_status;
        logic    enclosure_open_status;
        alert_t  new_alerts;
        alert_t  latched_alerts;
    } out_item_t;

    typedef struct packed {
        sample_t supply_temp_threshold;
        sample_t enclosure_temp_threshold;
        logic    supply_temp_enable;
        logic    power_fail_enable;
        logic    enclosure_temp_enable;
        logic    enclosure_open_enable;
    } cfg_t;

    // Control fields carried from the lane stage to the merge stage
    typedef struct packed {
        op_t    operation;
        logic   power_fail;
        logic   enclosure_open;
        alert_t rearm_mask;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/atam_lane.sv =====
// One averaging lane: sliding sample window, running sum and window average.
// Depends on atam_pkg.
`default_nettype none

module atam_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire atam_pkg::sample_t sample,
    output atam_pkg::sample_t      average
);
    import atam_pkg::*;

    sample_t window_reg [WINDOW_DEPTH];
    pos_t    pos_reg;
    pos_t    pos_next;
    sum_t    sum_reg;
    sum_t    sum_next;
    sample_t oldest;

    // Swap the oldest sample for the new one in the running sum
    always_comb
    begin
        oldest   = window_reg[pos_reg];
        sum_next = sum_reg - sum_t'(oldest) + sum_t'(sample);
        pos_next = pos_reg + pos_t'(1);
    end

    // Hold window, pointer and sum; advance on each tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
            begin
                window_reg[k] <= WINDOW_RESET;
            end
            pos_reg <= '0;
            sum_reg <= SUM_RESET;
        end
        else if (load)
        begin
            window_reg[pos_reg] <= sample;
            pos_reg             <= pos_next;
            sum_reg             <= sum_next;
        end
    end

    // Average is the sum divided by the window depth
    assign average = sum_reg[SUM_BITS-1:POS_BITS];

endmodule

`default_nettype wire

// ===== rtl/core/atam_merge.sv =====
// Merge stage: combines both lane averages and the status bits into shown
// values, alert latches and one result beat. Depends on atam_pkg.
`default_nettype none

module atam_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire atam_pkg::stage_t  item,
    input  wire atam_pkg::sample_t supply_avg,
    input  wire atam_pkg::sample_t enclosure_avg,
    input  wire atam_pkg::cfg_t    cfg,
    output atam_pkg::out_item_t    result
);
    import atam_pkg::*;

    sample_t supply_shown_reg;
    sample_t supply_shown_next;
    sample_t encl_shown_reg;
    sample_t encl_shown_next;
    logic    power_held_reg;
    logic    power_held_next;
    logic    open_held_reg;
    logic    open_held_next;
    alert_t  latches_reg;
    alert_t  latches_next;
    alert_t  fresh;

    // On a tick, sample unlatched channels, then latch any channel that trips; a rearm clears masked latches
    always_comb
    begin
        supply_shown_next = supply_shown_reg;
        encl_shown_next   = encl_shown_reg;
        power_held_next   = power_held_reg;
        open_held_next    = open_held_reg;
        fresh             = '0;
        latches_next      = latches_reg;
        case (item.operation)
            OP_REARM:
            begin
                latches_next = latches_reg & ~item.rearm_mask;
            end
            OP_TICK:
            begin
                if (!latches_reg[ALERT_SUPPLY])
                begin
                    supply_shown_next = supply_avg;
                end
                if (!latches_reg[ALERT_POWER])
                begin
                    power_held_next = item.power_fail;
                end
                if (!latches_reg[ALERT_ENCL])
                begin
                    encl_shown_next = enclosure_avg;
                end
                if (!latches_reg[ALERT_OPEN])
                begin
                    open_held_next = item.enclosure_open;
                end
                fresh[ALERT_SUPPLY] = cfg.supply_temp_enable && !latches_reg[ALERT_SUPPLY]
                                      && (supply_shown_next >= cfg.supply_temp_threshold);
                fresh[ALERT_POWER]  = cfg.power_fail_enable && !latches_reg[ALERT_POWER]
                                      && power_held_next;
                fresh[ALERT_ENCL]   = cfg.enclosure_temp_enable && !latches_reg[ALERT_ENCL]
                                      && (encl_shown_next >= cfg.enclosure_temp_threshold);
                fresh[ALERT_OPEN]   = cfg.enclosure_open_enable && !latches_reg[ALERT_OPEN]
                                      && open_held_next;
                latches_next = latches_reg | fresh;
            end
            default:
            begin
                latches_next = latches_reg;
            end
        endcase
    end

    // Hold shown values and latches between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_shown_reg <= '0;
            encl_shown_reg   <= '0;
            power_held_reg   <= 1'b0;
            open_held_reg    <= 1'b0;
            latches_reg      <= '0;
        end
        else if (load)
        begin
            supply_shown_reg <= supply_shown_next;
            encl_shown_reg   <= encl_shown_next;
            power_held_reg   <= power_held_next;
            open_held_reg    <= open_held_next;
            latches_reg      <= latches_next;
        end
    end

    // Form the result beat from the post-update state
    always_comb
    begin
        result.supply_average        = supply_shown_next;
        result.enclosure_average     = encl_shown_next;
        result.power_fail_status     = power_held_next;
        result.enclosure_open_status = open_held_next;
        result.new_alerts            = fresh;
        result.latched_alerts        = latches_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/averaged_temperature_alarm_monitor.sv =====
// Averaged temperature alarm monitor, top level. Depends on atam_pkg,
// atam_lane and atam_merge.
// Throughput: one item per cycle while no finished result beat is stalled.
// Path: lane stage, then merge stage into the output register.
// Reset: asynchronous, active low; windows return to 139 per entry, sums to
// 139 * depth, shown values and latches to 0, configuration registers to their defaults.
`default_nettype none

module averaged_temperature_alarm_monitor (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input item channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire atam_pkg::in_item_t                  in_data,
    // Result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output atam_pkg::out_item_t                      out_data,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [atam_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [atam_pkg::DATA_BITS-1:0]      pwdata,
    output logic [atam_pkg::DATA_BITS-1:0]           prdata,
    output logic                                     pready
);
    import atam_pkg::*;

    cfg_t      cfg_reg;
    reg_idx_t  reg_idx;
    logic      cfg_write;

    logic      in_fire;
    logic      out_stall;
    logic      s1_move;
    logic      s1_valid_reg;
    stage_t    s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t merged;
    sample_t   supply_avg;
    sample_t   enclosure_avg;
    logic      lane_load;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.supply_temp_threshold    <= THRESHOLD_RESET;
            cfg_reg.enclosure_temp_threshold <= THRESHOLD_RESET;
            cfg_reg.supply_temp_enable       <= 1'b1;
            cfg_reg.power_fail_enable        <= 1'b1;
            cfg_reg.enclosure_temp_enable    <= 1'b1;
            cfg_reg.enclosure_open_enable    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_SUPPLY_THR: cfg_reg.supply_temp_threshold    <= pwdata[SAMPLE_BITS-1:0];
                REG_ENCL_THR:   cfg_reg.enclosure_temp_threshold <= pwdata[SAMPLE_BITS-1:0];
                REG_SUPPLY_EN:  cfg_reg.supply_temp_enable       <= pwdata[0];
                REG_POWER_EN:   cfg_reg.power_fail_enable        <= pwdata[0];
                REG_ENCL_EN:    cfg_reg.enclosure_temp_enable    <= pwdata[0];
                REG_OPEN_EN:    cfg_reg.enclosure_open_enable    <= pwdata[0];
                default:        cfg_reg                          <= cfg_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (reg_idx)
            REG_SUPPLY_THR: prdata = DATA_BITS'(cfg_reg.supply_temp_threshold);
            REG_ENCL_THR:   prdata = DATA_BITS'(cfg_reg.enclosure_temp_threshold);
            REG_SUPPLY_EN:  prdata = DATA_BITS'(cfg_reg.supply_temp_enable);
            REG_POWER_EN:   prdata = DATA_BITS'(cfg_reg.power_fail_enable);
            REG_ENCL_EN:    prdata = DATA_BITS'(cfg_reg.enclosure_temp_enable);
            REG_OPEN_EN:    prdata = DATA_BITS'(cfg_reg.enclosure_open_enable);
            default:        prdata = '0;
        endcase
    end

    // Pipeline flow: stall only when a finished beat is still waiting
    assign out_stall = out_valid_reg && !out_ready;
    assign in_ready  = !out_stall || !s1_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign s1_move   = s1_valid_reg && !out_stall;
    assign lane_load = in_fire && (in_data.operation == OP_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (!out_stall)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Carry control fields alongside the lane update
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.operation      <= in_data.operation;
            s1_item_reg.power_fail     <= in_data.power_fail_in;
            s1_item_reg.enclosure_open <= in_data.enclosure_open_in;
            s1_item_reg.rearm_mask     <= in_data.rearm_mask;
        end
    end

    // Averaging lanes
    atam_lane u_supply_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (lane_load),
        .sample  (in_data.supply_sample),
        .average (supply_avg)
    );

    atam_lane u_encl_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (lane_load),
        .sample  (in_data.enclosure_sample),
        .average (enclosure_avg)
    );

    // Merge lanes and status into alerts
    atam_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_move),
        .item          (s1_item_reg),
        .supply_avg    (supply_avg),
        .enclosure_avg (enclosure_avg),
        .cfg           (cfg_reg),
        .result        (merged)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
